// ===== rtl/lpcp_pkg.sv =====
// Shared types and constants for the lidar point to camera projection core.
package lpcp_pkg;

    localparam int NUM_REGS    = 8;
    localparam int TRANS_BITS  = 20;  // signed translation entry, mm
    localparam int DEPTH_BITS  = 20;  // unsigned depth window bound, mm
    localparam int INTR_BITS   = 24;  // unsigned Q16.8 intrinsic
    localparam int DIM_BITS    = 12;  // image dimension and pixel index
    localparam int COLOR_BITS  = 8;
    localparam int OUT_BITS    = 2 * DIM_BITS + 3 * COLOR_BITS;

    localparam int C255    = 255;
    localparam int C200    = 200;
    localparam int C65025  = 65025;   // 255^2
    localparam int C160000 = 160000;  // 400^2

    localparam logic [63:0] FOCAL_RESET     = 64'd2147483776000;
    localparam logic [63:0] PRINCIPAL_RESET = 64'd1374389596160;
    localparam logic [63:0] IMAGE_RESET     = 64'd2621920;
    localparam logic [63:0] DEPTH_RESET     = 64'd104957600;

    typedef enum logic [2:0] {
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_TRANS,
        REG_FOCAL,
        REG_PRINCIPAL,
        REG_IMAGE,
        REG_DEPTH
    } reg_idx_t;

endpackage

// ===== rtl/lidar_point_camera_projection_core.sv =====
// Top level: lidar point range gate, camera transform, pinhole projection and depth colormap.
//
// One lidar point word per cycle is accepted and at most one pixel word comes out per
// point, in order; points that fall outside the depth window, behind the camera depth
// limit or off the image produce nothing. The length of the pipeline to the output
// register is set by the square root of the scaled range, which resolves one root bit
// per stage; the pixel division runs alongside it and the colour division takes eight
// more stages. A two-entry output buffer keeps the input open while one result waits;
// the pipeline freezes only when both entries are held.
module lidar_point_camera_projection_core #(
    parameter int COORD_BITS    = 20,
    parameter int ROT_FRAC_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // s_tdata: point_x, point_y, point_z (COORD_BITS each, signed), zero pad
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // m_tdata: pixel_u[11:0], pixel_v[23:12], red[31:24], green[39:32], blue[47:40]
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [lpcp_pkg::OUT_BITS-1:0]           m_tdata,
    input  logic                                    cfg_we,
    input  lpcp_pkg::reg_idx_t                      cfg_index,
    input  logic [((3*(ROT_FRAC_BITS+2) > 60) ? 3*(ROT_FRAC_BITS+2) : 60)-1:0] cfg_data
);
    import lpcp_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int F     = ROT_FRAC_BITS;
    localparam int RE    = F + 2;
    localparam int ROW_W = 3 * RE;
    localparam int TR_W  = 3 * TRANS_BITS;
    localparam int CFG_W = (ROW_W > TR_W) ? ROW_W : TR_W;
    localparam int PW    = RE + CB;          // rotation product
    localparam int AW    = PW + 2;           // row sum
    localparam int SH    = AW - F;           // row sum after the fraction shift
    localparam int CW    = ((SH > TRANS_BITS) ? SH : TRANS_BITS) + 1;  // camera coordinate
    localparam int SW    = 2 * CB;           // squared range
    localparam int RW    = SW + 18;          // scaled squared range (fits 400^2 * s)
    localparam int SQ    = RW / 2;           // root bits
    localparam int MSQW  = 2 * DEPTH_BITS;
    localparam int MUW   = CW + INTR_BITS + 1;
    localparam int UW    = MUW + 1;          // projected numerator
    localparam int LW    = CW + DIM_BITS + 1;
    localparam int CNW   = ((SQ > 29) ? SQ : 29) + 2;  // colour numerator
    localparam int KEEP  = 4;
    localparam int CH0   = 5;
    localparam int PREP  = CH0 + SQ;
    localparam int N     = PREP + 1 + COLOR_BITS;

    localparam logic [CFG_W-1:0] ONE     = CFG_W'(1);
    localparam logic [CFG_W-1:0] ROW_MSK = (ONE << ROW_W) - ONE;
    localparam logic [CFG_W-1:0] TR_MSK  = (ONE << TR_W) - ONE;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    logic [CFG_W-1:0] cfg_msk;

    always_comb begin
        unique case (cfg_index)
            REG_ROT0, REG_ROT1, REG_ROT2: cfg_msk = ROW_MSK;
            REG_TRANS:                    cfg_msk = TR_MSK;
            REG_FOCAL, REG_PRINCIPAL:     cfg_msk = (ONE << 48) - ONE;
            REG_IMAGE:                    cfg_msk = (ONE << 24) - ONE;
            REG_DEPTH:                    cfg_msk = (ONE << 40) - ONE;
            default:                      cfg_msk = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_ROT0]      <= ONE << (F + 2 * RE);
            cfg_reg[REG_ROT1]      <= ONE << (F + RE);
            cfg_reg[REG_ROT2]      <= ONE << F;
            cfg_reg[REG_TRANS]     <= '0;
            cfg_reg[REG_FOCAL]     <= CFG_W'(FOCAL_RESET);
            cfg_reg[REG_PRINCIPAL] <= CFG_W'(PRINCIPAL_RESET);
            cfg_reg[REG_IMAGE]     <= CFG_W'(IMAGE_RESET);
            cfg_reg[REG_DEPTH]     <= CFG_W'(DEPTH_RESET);
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_data & cfg_msk;
        end
    end

    logic [ROW_W-1:0]      rot_row [3];
    logic [DEPTH_BITS-1:0] mn, mx, wdiff;
    logic [INTR_BITS-1:0]  fx, fy, cx, cy;
    logic [DIM_BITS-1:0]   wd, ht;
    logic                  wz;

    always_comb begin
        rot_row[0] = cfg_reg[REG_ROT0][ROW_W-1:0];
        rot_row[1] = cfg_reg[REG_ROT1][ROW_W-1:0];
        rot_row[2] = cfg_reg[REG_ROT2][ROW_W-1:0];
        mn    = cfg_reg[REG_DEPTH][39:20];
        mx    = cfg_reg[REG_DEPTH][19:0];
        fx    = cfg_reg[REG_FOCAL][47:24];
        fy    = cfg_reg[REG_FOCAL][23:0];
        cx    = cfg_reg[REG_PRINCIPAL][47:24];
        cy    = cfg_reg[REG_PRINCIPAL][23:0];
        wd    = cfg_reg[REG_IMAGE][23:12];
        ht    = cfg_reg[REG_IMAGE][11:0];
        wdiff = mx - mn;
        wz    = (mx == mn);
    end

    // ---------------- flow control ----------------
    logic         en;
    logic [1:0]   cnt_reg;
    logic [N-1:0] v_reg;
    logic         keep3;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < N; k++) begin
                if (k != KEEP) v_reg[k] <= v_reg[k-1];
            end
            v_reg[KEEP] <= v_reg[KEEP-1] && keep3;
        end
    end

    // ---------------- stage 0: squares and rotation products ----------------
    typedef struct packed {
        logic [2:0][SW-1:0]      sq;
        logic [2:0][2:0][PW-1:0] prod;
    } st0_t;

    st0_t st0_reg, st0_next;

    always_comb begin
        logic signed [CB-1:0] pin [3];
        logic [CB-1:0]        ax;
        logic signed [RE-1:0] rent;
        pin[0] = s_tdata[CB-1:0];
        pin[1] = s_tdata[2*CB-1:CB];
        pin[2] = s_tdata[3*CB-1:2*CB];
        for (int i = 0; i < 3; i++) begin
            ax = pin[i][CB-1] ? CB'(-pin[i]) : CB'(pin[i]);
            st0_next.sq[i] = SW'(ax) * SW'(ax);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rent = rot_row[i][(2-j)*RE +: RE];
                st0_next.prod[i][j] = PW'(rent) * PW'(pin[j]);
            end
        end
    end

    always_ff @(posedge aclk) if (en) st0_reg <= st0_next;

    // ---------------- stage 1: sums and depth window squares ----------------
    typedef struct packed {
        logic [SW-1:0]        s;
        logic [2:0][AW-1:0]   acc;
        logic [MSQW-1:0]      mnsq;
        logic [MSQW-1:0]      mxsq;
        logic [MSQW+1:0]      msq;
    } st1_t;

    st1_t st1_reg, st1_next;

    always_comb begin
        logic [SW+1:0]         ssum;
        logic [DEPTH_BITS:0]   msum;
        ssum = (SW+2)'(st0_reg.sq[0]) + (SW+2)'(st0_reg.sq[1]) + (SW+2)'(st0_reg.sq[2]);
        st1_next.s = ssum[SW-1:0];
        for (int i = 0; i < 3; i++) begin
            st1_next.acc[i] = AW'(signed'(st0_reg.prod[i][0]))
                            + AW'(signed'(st0_reg.prod[i][1]))
                            + AW'(signed'(st0_reg.prod[i][2]));
        end
        msum          = (DEPTH_BITS+1)'(mn) + (DEPTH_BITS+1)'(mx);
        st1_next.mnsq = MSQW'(mn) * MSQW'(mn);
        st1_next.mxsq = MSQW'(mx) * MSQW'(mx);
        st1_next.msq  = (MSQW+2)'(msum) * (MSQW+2)'(msum);
    end

    always_ff @(posedge aclk) if (en) st1_reg <= st1_next;

    // ---------------- stage 2: range gate, camera coordinates, scaled range ----------------
    typedef struct packed {
        logic               rok;
        logic [2:0][CW-1:0] c;
        logic [RW-1:0]      s65;
        logic [RW-1:0]      s40;
        logic               near;
    } st2_t;

    st2_t st2_reg, st2_next;

    always_comb begin
        logic signed [AW-1:0]         a;
        logic signed [AW-1:0]         ash;
        logic signed [TRANS_BITS-1:0] tr;
        st2_next.rok = !(st1_reg.s < st1_reg.mnsq || st1_reg.s > st1_reg.mxsq);
        for (int i = 0; i < 3; i++) begin
            a   = st1_reg.acc[i];
            ash = a >>> F;
            tr  = cfg_reg[REG_TRANS][(2-i)*TRANS_BITS +: TRANS_BITS];
            st2_next.c[i] = CW'(ash) + CW'(tr);
        end
        st2_next.s65  = RW'(st1_reg.s) * RW'(C65025);
        st2_next.s40  = RW'(st1_reg.s) * RW'(C160000);
        st2_next.near = ({st1_reg.s, 2'b00} <= st1_reg.msq);
    end

    always_ff @(posedge aclk) if (en) st2_reg <= st2_next;

    // ---------------- stage 3: depth gate, projection products ----------------
    typedef struct packed {
        logic            rok;
        logic            dok;
        logic [MUW-1:0]  pu0, pu1, pv0, pv1;
        logic [LW-1:0]   lu, lv;
        logic [CW-1:0]   c2;
        logic [RW-1:0]   s65;
        logic [RW-1:0]   s40;
        logic            near;
    } st3_t;

    st3_t st3_reg, st3_next;

    always_comb begin
        logic signed [CW-1:0] c0, c1, c2, cmn;
        c0  = st2_reg.c[0];
        c1  = st2_reg.c[1];
        c2  = st2_reg.c[2];
        cmn = CW'(signed'({1'b0, mn}));
        st3_next.rok  = st2_reg.rok;
        st3_next.dok  = !(c2 < cmn || c2 <= CW'(0));
        st3_next.pu0  = MUW'(signed'({1'b0, fx})) * MUW'(c0);
        st3_next.pu1  = MUW'(signed'({1'b0, cx})) * MUW'(c2);
        st3_next.pv0  = MUW'(signed'({1'b0, fy})) * MUW'(c1);
        st3_next.pv1  = MUW'(signed'({1'b0, cy})) * MUW'(c2);
        st3_next.lu   = LW'(signed'({1'b0, wd})) * LW'(c2);
        st3_next.lv   = LW'(signed'({1'b0, ht})) * LW'(c2);
        st3_next.c2   = st2_reg.c[2];
        st3_next.s65  = st2_reg.s65;
        st3_next.s40  = st2_reg.s40;
        st3_next.near = st2_reg.near;
    end

    always_ff @(posedge aclk) if (en) st3_reg <= st3_next;

    // ---------------- stage 4: image gate, drop decision ----------------
    typedef struct packed {
        logic [UW-1:0] nu, nv, d;
        logic [RW-1:0] s65;
        logic [RW-1:0] s40;
        logic          near;
    } st4_t;

    st4_t st4_reg, st4_next;

    always_comb begin
        logic signed [UW-1:0] nu, nv, limu, limv;
        logic signed [CW-1:0] c2;
        nu   = UW'(signed'(st3_reg.pu0)) + UW'(signed'(st3_reg.pu1));
        nv   = UW'(signed'(st3_reg.pv0)) + UW'(signed'(st3_reg.pv1));
        limu = UW'(signed'(st3_reg.lu)) <<< 8;
        limv = UW'(signed'(st3_reg.lv)) <<< 8;
        c2   = st3_reg.c2;
        keep3 = st3_reg.rok && st3_reg.dok
             && !nu[UW-1] && (nu < limu) && !nv[UW-1] && (nv < limv);
        st4_next.nu   = nu;
        st4_next.nv   = nv;
        st4_next.d    = UW'(c2) << 8;
        st4_next.s65  = st3_reg.s65;
        st4_next.s40  = st3_reg.s40;
        st4_next.near = st3_reg.near;
    end

    always_ff @(posedge aclk) if (en) st4_reg <= st4_next;

    // ---------------- root and pixel division, one bit per stage ----------------
    typedef struct packed {
        logic [RW-1:0]       rad65, rad40;
        logic [SQ:0]         r65, r40;
        logic [SQ-1:0]       q65, q40;
        logic [UW-1:0]       nur, nvr, dv;
        logic [DIM_BITS-1:0] qu, qv;
        logic                near;
    } ch_t;

    ch_t ch_src;
    ch_t ch_reg [SQ];

    always_comb begin
        ch_src.rad65 = st4_reg.s65;
        ch_src.rad40 = st4_reg.s40;
        ch_src.r65   = '0;
        ch_src.r40   = '0;
        ch_src.q65   = '0;
        ch_src.q40   = '0;
        ch_src.nur   = st4_reg.nu;
        ch_src.nvr   = st4_reg.nv;
        ch_src.dv    = st4_reg.d;
        ch_src.qu    = '0;
        ch_src.qv    = '0;
        ch_src.near  = st4_reg.near;
    end

    for (genvar j = 0; j < SQ; j++) begin : g_ch
        localparam int QB = (j < DIM_BITS) ? DIM_BITS - 1 - j : 0;
        ch_t prv, nxt;
        if (j == 0) begin : g_first
            assign prv = ch_src;
        end else begin : g_rest
            assign prv = ch_reg[j-1];
        end

        always_comb begin
            logic [SQ+2:0] rt65, tt65, rt40, tt40, df65, df40;
            logic [UW-1:0] ds;
            nxt  = prv;
            rt65 = {prv.r65, prv.rad65[RW-1:RW-2]};
            tt65 = {1'b0, prv.q65, 2'b01};
            df65 = rt65 - tt65;
            rt40 = {prv.r40, prv.rad40[RW-1:RW-2]};
            tt40 = {1'b0, prv.q40, 2'b01};
            df40 = rt40 - tt40;
            nxt.rad65 = {prv.rad65[RW-3:0], 2'b00};
            nxt.rad40 = {prv.rad40[RW-3:0], 2'b00};
            if (rt65 >= tt65) begin
                nxt.r65 = df65[SQ:0];
                nxt.q65 = {prv.q65[SQ-2:0], 1'b1};
            end else begin
                nxt.r65 = rt65[SQ:0];
                nxt.q65 = {prv.q65[SQ-2:0], 1'b0};
            end
            if (rt40 >= tt40) begin
                nxt.r40 = df40[SQ:0];
                nxt.q40 = {prv.q40[SQ-2:0], 1'b1};
            end else begin
                nxt.r40 = rt40[SQ:0];
                nxt.q40 = {prv.q40[SQ-2:0], 1'b0};
            end
            ds = '0;
            if (j < DIM_BITS) begin
                // quotient bit DIM_BITS-1-j of nu / (256 * zc)
                ds = prv.dv << QB;
                if (prv.nur >= ds) begin
                    nxt.nur = prv.nur - ds;
                    nxt.qu[QB] = 1'b1;
                end
                if (prv.nvr >= ds) begin
                    nxt.nvr = prv.nvr - ds;
                    nxt.qv[QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) if (en) ch_reg[j] <= nxt;
    end

    // ---------------- colour numerators ----------------
    typedef struct packed {
        logic [CNW-1:0]        rb, rr, rg;
        logic [COLOR_BITS-1:0] qb, qr, qg;
        logic [DIM_BITS-1:0]   qu, qv;
    } cd_t;

    cd_t cd_src;
    cd_t cd_reg [COLOR_BITS];

    always_comb begin
        logic [CNW-1:0] isq65, csq65, isq40, csq40, mnw, mxw, mw;
        ch_t            lst;
        lst   = ch_reg[SQ-1];
        isq65 = CNW'(lst.q65);
        csq65 = isq65 + CNW'(lst.r65 != '0);   // ceiling of the root
        isq40 = CNW'(lst.q40);
        csq40 = isq40 + CNW'(lst.r40 != '0);
        mnw   = CNW'(mn);
        mxw   = CNW'(mx);
        mw    = mnw + mxw;
        cd_src.rb = isq65 - mnw * CNW'(C255);
        cd_src.rr = mxw * CNW'(C255) - csq65;
        cd_src.rg = lst.near ? (mw * CNW'(C200) - csq40) : (isq40 - mw * CNW'(C200));
        cd_src.qb = '0;
        cd_src.qr = '0;
        cd_src.qg = '0;
        cd_src.qu = lst.qu;
        cd_src.qv = lst.qv;
    end

    cd_t prep_reg;
    always_ff @(posedge aclk) if (en) prep_reg <= cd_src;

    for (genvar k = 0; k < COLOR_BITS; k++) begin : g_cd
        cd_t prv, nxt;
        if (k == 0) begin : g_first
            assign prv = prep_reg;
        end else begin : g_rest
            assign prv = cd_reg[k-1];
        end

        always_comb begin
            logic [CNW-1:0] ws;
            nxt = prv;
            ws  = CNW'(wdiff) << (COLOR_BITS - 1 - k);
            if (prv.rb >= ws) begin
                nxt.rb = prv.rb - ws;
                nxt.qb[COLOR_BITS-1-k] = 1'b1;
            end
            if (prv.rr >= ws) begin
                nxt.rr = prv.rr - ws;
                nxt.qr[COLOR_BITS-1-k] = 1'b1;
            end
            if (prv.rg >= ws) begin
                nxt.rg = prv.rg - ws;
                nxt.qg[COLOR_BITS-1-k] = 1'b1;
            end
        end

        always_ff @(posedge aclk) if (en) cd_reg[k] <= nxt;
    end

    // ---------------- output buffer ----------------
    logic [OUT_BITS-1:0] res, head_reg, skid_reg;
    logic                push, pop;

    always_comb begin
        cd_t fin;
        fin = cd_reg[COLOR_BITS-1];
        if (wz) begin
            res = {COLOR_BITS'(0), COLOR_BITS'(C200), COLOR_BITS'(C255), fin.qv, fin.qu};
        end else begin
            res = {fin.qb, fin.qg, fin.qr, fin.qv, fin.qu};
        end
    end

    assign push     = en && v_reg[N-1];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            unique case (cnt_reg)
                2'd0: if (push) cnt_reg <= 2'd1;
                2'd1: begin
                    if (push && !pop) cnt_reg <= 2'd2;
                    else if (!push && pop) cnt_reg <= 2'd0;
                end
                2'd2: if (pop) cnt_reg <= 2'd1;
                default: cnt_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((cnt_reg == 2'd0 && push) || (cnt_reg == 2'd1 && push && pop)) head_reg <= res;
        if (cnt_reg == 2'd1 && push && !pop) skid_reg <= res;
        if (cnt_reg == 2'd2 && pop) head_reg <= skid_reg;
    end

    // ---------------- checks ----------------
    a_flat_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && wz |-> m_tdata[31:24] == 8'd255 && m_tdata[39:32] == 8'd200)
        else $error("flat depth window colour wrong");

    a_red_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (9'(m_tdata[31:24]) + 9'(m_tdata[47:40]) == 9'd255)
                  || (9'(m_tdata[31:24]) + 9'(m_tdata[47:40]) == 9'd254))
        else $error("red and blue do not complement");

    a_col_on_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:0] < wd)
        else $error("column off image");

    a_row_on_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:12] < ht)
        else $error("row off image");

endmodule

// ===== tb/lpcp_checker.sv =====
// Checker for the projection core: predicts pixel words from point words and compares.
module lpcp_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [63:0]         s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [47:0]         m_tdata,
    input  logic                cfg_we,
    input  lpcp_pkg::reg_idx_t  cfg_index,
    input  logic [59:0]         cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);
    import lpcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [59:0] regs [NUM_REGS];
    logic [47:0] pixel_q [$];

    function automatic int reg_bits(input int idx);
        case (idx)
            REG_ROT0, REG_ROT1, REG_ROT2: return 54;
            REG_TRANS:                    return 60;
            REG_FOCAL, REG_PRINCIPAL:     return 48;
            REG_IMAGE:                    return 24;
            default:                      return 40;
        endcase
    endfunction

    function automatic longint sext(input longint unsigned v, input int bits);
        longint unsigned m;
        m = (64'd1 << bits) - 1;
        v &= m;
        if (v[bits-1]) return longint'(v) - longint'(64'd1 << bits);
        return longint'(v);
    endfunction

    // Returns 1 and the pixel word when the point passes the range and depth gates and lands on the image.
    function automatic bit project_point(input logic [59:0] pt, output logic [47:0] px);
        longint p [3];
        longint c [3];
        longint acc, fx, fy, cx, cy, wd, ht, nu, nv;
        longint unsigned s, mn, mx, w, a, s255, s400, m, red, green, blue;
        px = '0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = sext(pt >> (20 * i), 20);
            a = (p[i] < 0) ? -p[i] : p[i];
            s += a * a;
        end
        mn = (regs[REG_DEPTH] >> 20) & 64'hFFFFF;
        mx = regs[REG_DEPTH] & 64'hFFFFF;
        if (s < mn * mn || s > mx * mx) return 0;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += sext(regs[i] >> ((2 - j) * 18), 18) * p[j];
            c[i] = (acc >>> 16) + sext(regs[REG_TRANS] >> ((2 - i) * 20), 20);
        end
        if (c[2] < longint'(mn) || c[2] <= 0) return 0;
        fx = (regs[REG_FOCAL] >> 24) & 64'hFFFFFF;
        fy = regs[REG_FOCAL] & 64'hFFFFFF;
        cx = (regs[REG_PRINCIPAL] >> 24) & 64'hFFFFFF;
        cy = regs[REG_PRINCIPAL] & 64'hFFFFFF;
        wd = (regs[REG_IMAGE] >> 12) & 64'hFFF;
        ht = regs[REG_IMAGE] & 64'hFFF;
        nu = fx * c[0] + cx * c[2];
        nv = fy * c[1] + cy * c[2];
        if (nu < 0 || nu >= wd * 256 * c[2]) return 0;
        if (nv < 0 || nv >= ht * 256 * c[2]) return 0;
        w = mx - mn;
        if (w == 0) begin
            red = C255; green = C200; blue = 0;
        end else begin
            // each channel is the largest k whose threshold the range still clears
            s255 = C65025 * s;
            s400 = C160000 * s;
            m = mx + mn;
            blue = 0;
            for (longint unsigned k = 1; k <= 255; k++) begin
                a = k * w + 255 * mn;
                if (a * a > s255) break;
                blue = k;
            end
            red = 0;
            for (longint unsigned k = 1; k <= 255; k++) begin
                if (k * w > 255 * mx) break;
                a = 255 * mx - k * w;
                if (a * a < s255) break;
                red = k;
            end
            green = 0;
            if (4 * s <= m * m) begin
                for (longint unsigned k = 1; k <= 200; k++) begin
                    if (k * w > 200 * m) break;
                    a = 200 * m - k * w;
                    if (a * a < s400) break;
                    green = k;
                end
            end else begin
                for (longint unsigned k = 1; k <= 200; k++) begin
                    a = k * w + 200 * m;
                    if (a * a > s400) break;
                    green = k;
                end
            end
        end
        px[11:0]  = 12'(nu / (256 * c[2]));
        px[23:12] = 12'(nv / (256 * c[2]));
        px[31:24] = red[7:0];
        px[39:32] = green[7:0];
        px[47:40] = blue[7:0];
        return 1;
    endfunction

    always @(posedge aclk) begin
        logic [47:0] px, want;
        if (!aresetn) begin
            regs[REG_ROT0]      <= 60'd1 << 52;
            regs[REG_ROT1]      <= 60'd1 << 34;
            regs[REG_ROT2]      <= 60'd1 << 16;
            regs[REG_TRANS]     <= '0;
            regs[REG_FOCAL]     <= FOCAL_RESET[59:0];
            regs[REG_PRINCIPAL] <= PRINCIPAL_RESET[59:0];
            regs[REG_IMAGE]     <= IMAGE_RESET[59:0];
            regs[REG_DEPTH]     <= DEPTH_RESET[59:0];
            pixel_q.delete();
            fail_count <= 0;
            checked <= 0;
            pending <= 0;
        end else begin
            if (cfg_we)
                regs[cfg_index] <= cfg_data & ((60'd1 << reg_bits(cfg_index)) - 1)
                                 | ((reg_bits(cfg_index) == 60) ? cfg_data : 60'd0);
            if (s_tvalid && s_tready && project_point(s_tdata[59:0], px))
                pixel_q.insert(pixel_q.size(), px);
            if (m_tvalid && m_tready) begin
                checked <= checked + 1;
                if (pixel_q.size() == 0) begin
                    $error("pixel word %h with none expected", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (want != m_tdata) begin
                        fail_count <= fail_count + 1;
                        if (want[11:0] != m_tdata[11:0])
                            $error("pixel_u exp %0d got %0d", want[11:0], m_tdata[11:0]);
                        if (want[23:12] != m_tdata[23:12])
                            $error("pixel_v exp %0d got %0d", want[23:12], m_tdata[23:12]);
                        if (want[31:24] != m_tdata[31:24])
                            $error("red exp %0d got %0d", want[31:24], m_tdata[31:24]);
                        if (want[39:32] != m_tdata[39:32])
                            $error("green exp %0d got %0d", want[39:32], m_tdata[39:32]);
                        if (want[47:40] != m_tdata[47:40])
                            $error("blue exp %0d got %0d", want[47:40], m_tdata[47:40]);
                    end
                end
            end
            pending <= pixel_q.size();
        end
    end
endmodule

// ===== tb/tb_lidar_point_camera_projection_core.sv =====
// Testbench top: point stimulus, register phases, handshake pressure and verdict.
module tb_lidar_point_camera_projection_core;
    import lpcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        cfg_we = 0;
    reg_idx_t    cfg_index = REG_ROT0;
    logic [59:0] cfg_data = '0;

    int  fail_count, pending, checked;
    int  points_sent = 0;
    int  stall_cycles = 0;
    bit  idle_on = 1;
    bit  long_hold = 0;
    int  span = 640;   // x half-width per 1000 mm of depth for on-image points
    int  vspan = 480;

    lidar_point_camera_projection_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lpcp_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random ready bursts, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_point(input int x, input int y, input int z);
        s_tvalid <= 1;
        s_tdata  <= {4'd0, 20'(z), 20'(y), 20'(x)};
        do @(posedge aclk); while (!s_tready);
        points_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic send_raw(input logic [59:0] v);
        send_point(int'(v[19:0]), int'(v[39:20]), int'(v[59:40]));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [59:0] v);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
    endtask

    function automatic logic [53:0] rot_row(input int a, input int b, input int c);
        return {18'(a), 18'(b), 18'(c)};
    endfunction

    task automatic write_defaults();
        write_reg(REG_ROT0, 60'd1 << 52);
        write_reg(REG_ROT1, 60'd1 << 34);
        write_reg(REG_ROT2, 60'd1 << 16);
        write_reg(REG_TRANS, '0);
        write_reg(REG_FOCAL, FOCAL_RESET[59:0]);
        write_reg(REG_PRINCIPAL, PRINCIPAL_RESET[59:0]);
        write_reg(REG_IMAGE, IMAGE_RESET[59:0]);
        write_reg(REG_DEPTH, DEPTH_RESET[59:0]);
    endtask

    // mostly points in front of the camera inside the view, some pure noise
    task automatic random_points(input int n, input int zlo, input int zhi);
        int x, y, z, lx, ly;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_raw(60'({$urandom, $urandom}));
            end else begin
                z  = $urandom_range(zlo, zhi);
                lx = z * span / 1000;
                ly = z * vspan / 1000;
                x  = int'($urandom_range(0, 2 * lx + 2)) - lx - 1;
                y  = int'($urandom_range(0, 2 * ly + 2)) - ly - 1;
                send_point(x, y, z);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset settings: extremes of the fields and image/window edges
        span = 320; vspan = 240;
        send_point(-524288, -524288, -524288);
        send_point(524287, 524287, 524287);
        send_point(0, 0, 0);
        send_point(0, 0, 100);
        send_point(0, 0, 99);
        send_point(0, 0, 100000);
        send_point(0, 0, 100001);
        send_point(0, 0, 500);
        send_point(639, 0, 1000);
        send_point(640, 0, 1000);
        send_point(-640, 0, 1000);
        send_point(-641, 0, 1000);
        send_point(0, 479, 1000);
        send_point(0, 480, 1000);
        send_point(0, -480, 1000);
        send_point(0, -481, 1000);
        send_point(30000, 40000, 50000);
        random_points(230, 150, 20000);
        drain();

        // rotated frame, offsets, wide window from zero, receiver hold-off
        write_reg(REG_ROT0, 60'(rot_row(0, -65536, 0)));
        write_reg(REG_ROT1, 60'(rot_row(65536, 0, 0)));
        write_reg(REG_ROT2, 60'(rot_row(0, 0, 65536)));
        write_reg(REG_TRANS, {20'(50), 20'(-30), 20'(100)});
        write_reg(REG_FOCAL, 60'({24'(700 * 256 + 77), 24'(650 * 256 + 3)}));
        write_reg(REG_PRINCIPAL, 60'({24'(640 * 256 + 128), 24'(360 * 256 + 200)}));
        write_reg(REG_IMAGE, 60'({12'd1280, 12'd720}));
        write_reg(REG_DEPTH, 60'({20'd0, 20'hFFFFF}));
        cfg_we <= 0;
        @(posedge aclk);
        send_point(0, 0, -100);   // camera depth lands on zero
        send_point(0, 0, -99);
        long_hold = 1;
        random_points(250, 50, 30000);
        drain();

        // zero-width window; sender pauses midway until all results are in
        write_defaults();
        write_reg(REG_DEPTH, 60'({20'd5000, 20'd5000}));
        cfg_we <= 0;
        @(posedge aclk);
        send_point(0, 0, 5000);
        send_point(3000, 0, 4000);
        send_point(0, 3000, 4000);
        random_points(100, 4000, 6000);
        drain();
        random_points(100, 4990, 5010);
        drain();

        // empty window, then zero image width
        write_reg(REG_DEPTH, 60'({20'd6000, 20'd5000}));
        cfg_we <= 0;
        random_points(60, 4000, 7000);
        drain();
        write_reg(REG_DEPTH, DEPTH_RESET[59:0]);
        write_reg(REG_IMAGE, 60'({12'd0, 12'd480}));
        cfg_we <= 0;
        random_points(60, 200, 9000);
        drain();

        // fully random registers, then the widest depth window
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(reg_idx_t'(r), 60'({$urandom, $urandom}));
        write_reg(REG_DEPTH, 60'({20'd0, 20'hFFFFF}));
        cfg_we <= 0;
        random_points(150, 1, 524287);
        drain();

        // largest image, extreme intrinsics and rotation entries
        write_reg(REG_ROT0, 60'(rot_row(131071, 0, -131072)));
        write_reg(REG_ROT1, 60'(rot_row(0, 65536, 0)));
        write_reg(REG_ROT2, 60'(rot_row(0, 0, 65536)));
        write_reg(REG_TRANS, {20'h7FFFF, 20'h80000, 20'd0});
        write_reg(REG_FOCAL, 60'({24'hFFFFFF, 24'd256}));
        write_reg(REG_PRINCIPAL, 60'({24'd0, 24'hFFFFFF}));
        write_reg(REG_IMAGE, 60'({12'hFFF, 12'hFFF}));
        cfg_we <= 0;
        random_points(150, 100, 524287);
        drain();

        // back to reset values, no idling on either side
        write_defaults();
        cfg_we <= 0;
        idle_on = 0;
        span = 640; vspan = 480;
        random_points(300, 150, 20000);
        drain();

        $display("sent %0d points over eight register settings, %0d pixel words checked",
                 points_sent, checked);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
